// ===== rtl/mcpg_pkg.sv =====
package mcpg_pkg;

	localparam int LEVEL_W     = 36;
	localparam int WORD_W      = 32;
	localparam int CHAN_W      = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WORD_W-1:0] FOREVER = '1;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_SWITCH = 3'd1,
		OP_PWM    = 3'd2,
		OP_TIMING = 3'd3,
		OP_PORT   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAN = 2'd1,
		ST_NOT_CFG  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_TICK,
		K_SWITCH,
		K_PWM,
		K_TIMING,
		K_PORT,
		K_NOP,
		K_BAD
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TICK,
		BK_RMW,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [CHAN_W-1:0] channel;
		logic [WORD_W-1:0] repeat_count;
		logic              pwm_on;
		logic [WORD_W-1:0] mark_ms;
		logic [WORD_W-1:0] space_ms;
		logic              enable_flag;
		logic              invert_flag;
	} cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] drive_levels;
		logic [LEVEL_W-1:0] override_mask;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAN_W-1:0] chan;
		logic [WORD_W-1:0] count;
		logic              pwm_on;
		logic [WORD_W-1:0] mark;
		logic [WORD_W-1:0] space;
		logic              en;
		logic              inv;
	} job_t;

endpackage

// ===== rtl/mcpg_ram.sv =====
module mcpg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 36
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/mcpg_queue.sv =====
module mcpg_queue import mcpg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mcpg_front.sv =====
module mcpg_front import mcpg_pkg::*; #(
	parameter int CHANNELS = 36
) (
	input  cmd_t cmd,
	output job_t job
);

	localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(CHANNELS);

	logic bad_chan;

	assign bad_chan = ({1'b0, cmd.channel} >= CH_LIMIT);

	always_comb begin
		job.chan   = cmd.channel;
		job.count  = cmd.repeat_count;
		job.pwm_on = cmd.pwm_on;
		job.mark   = cmd.mark_ms;
		job.space  = cmd.space_ms;
		job.en     = cmd.enable_flag;
		job.inv    = cmd.invert_flag;
		case (op_t'(cmd.opcode))
			OP_TICK:   job.kind = K_TICK;
			OP_SWITCH: job.kind = K_SWITCH;
			OP_PWM:    job.kind = K_PWM;
			OP_TIMING: job.kind = K_TIMING;
			OP_PORT:   job.kind = K_PORT;
			default:   job.kind = K_NOP;
		endcase
		if ((cmd.opcode inside {[OP_SWITCH:OP_PORT]}) && bad_chan) begin
			job.kind = K_BAD;
		end
	end

endmodule

// ===== rtl/mcpg_back.sv =====
module mcpg_back import mcpg_pkg::*; #(
	parameter int CHANNELS = 36
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam logic [CNT_W-1:0] TK_LAST = CNT_W'(CHANNELS);

	bk_state_t state_q, state_d;

	logic [CHANNELS-1:0] req_q, req_d;
	logic [CHANNELS-1:0] cur_q, cur_d;
	logic [CHANNELS-1:0] pwm_q, pwm_d;
	logic [CHANNELS-1:0] pin_q, pin_d;
	logic [CHANNELS-1:0] en_q, en_d;
	logic [CHANNELS-1:0] inv_q, inv_d;
	logic [CHANNELS-1:0] cnt_vld_q, cnt_vld_d;
	logic [CHANNELS-1:0] tim_vld_q, tim_vld_d;

	job_t                job_q;
	status_t             status_q, status_d;
	logic [CNT_W-1:0]    tk_q;
	logic [CH_W-1:0]     tk_idx;
	logic [CH_W-1:0]     hch;
	logic [CH_W-1:0]     hch_q;
	logic                proc_s1;
	logic [CH_W-1:0]     idx_s1;
	logic                cvld_s1;
	logic                tvld_s1;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic                out_free;

	logic                cnt_we;
	logic [CH_W-1:0]     cnt_waddr;
	logic [2*WORD_W-1:0] cnt_wdata;
	logic [CH_W-1:0]     cnt_raddr;
	logic [2*WORD_W-1:0] cnt_rdata;
	logic                tim_we;
	logic [CH_W-1:0]     tim_waddr;
	logic [2*WORD_W-1:0] tim_wdata;
	logic [2*WORD_W-1:0] tim_rdata;

	logic [WORD_W-1:0]   rd_t, rd_p, rd_m, rd_s;
	logic                tk_act, tk_r2;
	logic [WORD_W-1:0]   tk_t, tk_p;
	logic [WORD_W-1:0]   rm_p;
	logic [LEVEL_W-1:0]  pin_ext, pwm_ext;

	assign tk_idx   = tk_q[CH_W-1:0];
	assign hch      = job.chan[CH_W-1:0];
	assign hch_q    = job_q.chan[CH_W-1:0];
	assign out_free = !rsp_valid_q || rsp_ready;
	assign job_pop  = (state_q == BK_IDLE) && job_valid;

	assign rd_t = cvld_s1 ? cnt_rdata[WORD_W-1:0]        : '0;
	assign rd_p = cvld_s1 ? cnt_rdata[2*WORD_W-1:WORD_W] : '0;
	assign rd_m = tvld_s1 ? tim_rdata[WORD_W-1:0]        : '0;
	assign rd_s = tvld_s1 ? tim_rdata[2*WORD_W-1:WORD_W] : '0;

	mcpg_ram #(.WIDTH(2*WORD_W), .DEPTH(CHANNELS)) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	mcpg_ram #(.WIDTH(2*WORD_W), .DEPTH(CHANNELS)) u_tim_ram (
		.clk  (clk),
		.we   (tim_we),
		.waddr(tim_waddr),
		.wdata(tim_wdata),
		.raddr(tk_idx),
		.rdata(tim_rdata)
	);

	// per-channel tick step
	always_comb begin
		tk_act = proc_s1 && en_q[idx_s1] && !pwm_q[idx_s1];
		tk_r2  = (rd_t == WORD_W'(1)) ? !req_q[idx_s1] : req_q[idx_s1];
		tk_t   = (rd_t != '0) ? rd_t - 1'b1 : rd_t;
		tk_p   = rd_p;
		if (tk_r2 != cur_q[idx_s1]) begin
			if (tk_r2) begin
				tk_t = rd_m;
			end else if (rd_p == '0) begin
				tk_t = '0;
			end else if (rd_p == FOREVER) begin
				tk_t = rd_s;
			end else begin
				tk_p = rd_p - 1'b1;
				tk_t = (rd_p == WORD_W'(1)) ? '0 : rd_s;
			end
		end
	end

	// switch / pwm read-modify-write of the repeat count
	always_comb begin
		rm_p = rd_p;
		case (job_q.kind)
			K_SWITCH: begin
				if (job_q.count != '0) begin
					if (rd_p == '0) begin
						rm_p = job_q.count;
					end
				end else begin
					rm_p = '0;
				end
			end
			K_PWM: begin
				if (!job_q.pwm_on) begin
					rm_p = '0;
				end
			end
			default: rm_p = rd_p;
		endcase
	end

	always_comb begin
		cnt_raddr = (state_q == BK_TICK) ? tk_idx : hch;
		tim_we    = job_pop && (job.kind == K_TIMING);
		tim_waddr = hch;
		tim_wdata = {job.space, job.mark};
		cnt_we    = 1'b0;
		cnt_waddr = idx_s1;
		cnt_wdata = {tk_p, tk_t};
		if (state_q == BK_RMW) begin
			cnt_we    = 1'b1;
			cnt_waddr = hch_q;
			cnt_wdata = {rm_p, rd_t};
		end else if (tk_act) begin
			cnt_we = 1'b1;
		end
	end

	always_comb begin
		req_d     = req_q;
		cur_d     = cur_q;
		pwm_d     = pwm_q;
		pin_d     = pin_q;
		en_d      = en_q;
		inv_d     = inv_q;
		cnt_vld_d = cnt_vld_q;
		tim_vld_d = tim_vld_q;
		if (cnt_we) begin
			cnt_vld_d[cnt_waddr] = 1'b1;
		end
		if (tim_we) begin
			tim_vld_d[tim_waddr] = 1'b1;
		end
		if (tk_act) begin
			req_d[idx_s1] = tk_r2;
			cur_d[idx_s1] = tk_r2;
			if (tk_r2 != cur_q[idx_s1]) begin
				pin_d[idx_s1] = inv_q[idx_s1] ^ tk_r2;
			end
		end
		if (job_pop && (job.kind == K_PORT)) begin
			en_d[hch]  = job.en;
			inv_d[hch] = job.inv;
			pin_d[hch] = job.en && (job.inv ^ cur_q[hch]);
		end
		if (state_q == BK_RMW) begin
			case (job_q.kind)
				K_SWITCH: begin
					if (job_q.count != '0) begin
						if (rd_p == '0) begin
							req_d[hch_q] = 1'b1;
						end
					end else begin
						req_d[hch_q] = 1'b0;
					end
				end
				K_PWM: begin
					if (job_q.pwm_on) begin
						pwm_d[hch_q] = 1'b1;
					end else begin
						cur_d[hch_q] = 1'b1;
						req_d[hch_q] = 1'b0;
						pwm_d[hch_q] = 1'b0;
					end
				end
				default: req_d = req_q;
			endcase
		end
	end

	always_comb begin
		case (job.kind)
			K_BAD:           status_d = ST_BAD_CHAN;
			K_SWITCH, K_PWM: status_d = en_q[hch] ? ST_OK : ST_NOT_CFG;
			default:         status_d = ST_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					case (job.kind)
						K_TICK:          state_d = BK_TICK;
						K_SWITCH, K_PWM: state_d = en_q[hch] ? BK_RMW : BK_DONE;
						default:         state_d = BK_DONE;
					endcase
				end
			end
			BK_TICK: begin
				if (tk_q == TK_LAST) begin
					state_d = BK_DONE;
				end
			end
			BK_RMW:  state_d = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	if (CHANNELS >= LEVEL_W) begin : g_wide
		assign pin_ext = pin_q[LEVEL_W-1:0];
		assign pwm_ext = pwm_q[LEVEL_W-1:0];
	end else begin : g_narrow
		assign pin_ext = {{(LEVEL_W-CHANNELS){1'b0}}, pin_q};
		assign pwm_ext = {{(LEVEL_W-CHANNELS){1'b0}}, pwm_q};
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		idx_s1  <= tk_idx;
		cvld_s1 <= cnt_vld_q[cnt_raddr];
		tvld_s1 <= tim_vld_q[tk_idx];
		if (state_q == BK_DONE && out_free) begin
			rsp_q.drive_levels  <= pin_ext;
			rsp_q.override_mask <= pwm_ext;
			rsp_q.status        <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			req_q       <= '0;
			cur_q       <= '0;
			pwm_q       <= '0;
			pin_q       <= '0;
			en_q        <= '0;
			inv_q       <= '0;
			cnt_vld_q   <= '0;
			tim_vld_q   <= '0;
			status_q    <= ST_OK;
			tk_q        <= '0;
			proc_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			req_q     <= req_d;
			cur_q     <= cur_d;
			pwm_q     <= pwm_d;
			pin_q     <= pin_d;
			en_q      <= en_d;
			inv_q     <= inv_d;
			cnt_vld_q <= cnt_vld_d;
			tim_vld_q <= tim_vld_d;
			proc_s1   <= (state_q == BK_TICK) && (tk_q != TK_LAST);
			if (job_pop) begin
				status_q <= status_d;
				tk_q     <= '0;
			end else if (state_q == BK_TICK && tk_q != TK_LAST) begin
				tk_q <= tk_q + 1'b1;
			end
			if (state_q == BK_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/multi_channel_pulse_generator_unit.sv =====
// Multi-channel mark/space pulse generator.
// cmd channel (valid/ready) carries one command transaction: a 1 ms tick, a
// channel switch, a pwm override, a timing write or a port flag write.
// rsp channel (valid/ready) returns one transaction per command with the pin
// drive vector, the override mask and a status code.
// Commands enter a two-entry queue; cmd_ready drops only when it is full.
// A tick makes the sequencer visit every channel, one channel per cycle,
// through the count and timing memories; switch and pwm on a configured
// channel do one read-modify-write of the count memory, and the other
// commands go straight to the response.
// The back end takes the next command from the queue only once the
// previous response has been registered.
// Reset clears all channel state; memory entries read as zero until
// written, so no clearing pass is needed.
// A stalled receiver holds the response in the output register; the back
// end finishes the next command and then waits, while the queue keeps
// accepting until full.
module multi_channel_pulse_generator_unit import mcpg_pkg::*; #(
	parameter int CHANNELS = 36
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	job_t front_job;
	job_t head_job;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign cmd_ready = !q_full;

	mcpg_front #(.CHANNELS(CHANNELS)) u_front (
		.cmd(cmd),
		.job(front_job)
	);

	mcpg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_valid),
		.push_data(front_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (head_job),
		.empty    (q_empty)
	);

	mcpg_back #(.CHANNELS(CHANNELS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!q_empty),
		.job      (head_job),
		.job_pop  (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/mcpg_checker.sv =====
module mcpg_checker import mcpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	logic [2:0] pending_q;
	logic       cmd_acc;
	logic       rsp_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// transactions accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_acc && !rsp_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (rsp_acc && !cmd_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("response valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> pending_q != 3'd0)
		else $error("response without a command");

	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(QUEUE_DEPTH + 2))
		else $error("more commands in flight than storage allows");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3)
		else $error("undefined status code");

endmodule

bind multi_channel_pulse_generator_unit mcpg_checker u_mcpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

// ===== sim/tb_multi_channel_pulse_generator_unit.sv =====
`timescale 1ns / 1ps

import mcpg_pkg::*;

localparam int TB_CHANNELS = 36;

class pulse_checker;
	logic [LEVEL_W-1:0] want_bits;
	logic [LEVEL_W-1:0] cur_bits;
	logic [LEVEL_W-1:0] pwm_bits;
	logic [LEVEL_W-1:0] pin_bits;
	logic [WORD_W-1:0]  remain [TB_CHANNELS];
	logic [WORD_W-1:0]  pulses [TB_CHANNELS];
	logic [WORD_W-1:0]  mark_tab [TB_CHANNELS];
	logic [WORD_W-1:0]  space_tab [TB_CHANNELS];
	logic               en_tab [TB_CHANNELS];
	logic               inv_tab [TB_CHANNELS];
	rsp_t               expected_q [$];
	int                 n_cmd;
	int                 n_ticks;
	int                 n_edges;
	int                 n_rsp;
	int                 n_err;

	function new();
		want_bits = '0;
		cur_bits  = '0;
		pwm_bits  = '0;
		pin_bits  = '0;
		for (int i = 0; i < TB_CHANNELS; i++) begin
			remain[i]    = '0;
			pulses[i]    = '0;
			mark_tab[i]  = '0;
			space_tab[i] = '0;
			en_tab[i]    = 1'b0;
			inv_tab[i]   = 1'b0;
		end
		n_cmd   = 0;
		n_ticks = 0;
		n_edges = 0;
		n_rsp   = 0;
		n_err   = 0;
	endfunction

	function void tick_one(int i);
		if (remain[i] != 0) begin
			remain[i] = remain[i] - 1;
			if (remain[i] == 0)
				want_bits[i] = ~want_bits[i];
		end
		if (want_bits[i] == cur_bits[i])
			return;
		n_edges++;
		cur_bits[i] = want_bits[i];
		pin_bits[i] = inv_tab[i] ^ want_bits[i];
		if (want_bits[i]) begin
			remain[i] = mark_tab[i];
		end else if (pulses[i] == 0) begin
			remain[i] = '0;
		end else if (pulses[i] != FOREVER) begin
			pulses[i] = pulses[i] - 1;
			remain[i] = (pulses[i] == 0) ? '0 : space_tab[i];
		end else begin
			remain[i] = space_tab[i];
		end
	endfunction

	function void apply_cmd(cmd_t c);
		rsp_t    e;
		status_t st;
		int      ch;
		st = ST_OK;
		ch = int'(c.channel);
		n_cmd++;
		case (c.opcode)
			OP_TICK: begin
				n_ticks++;
				for (int i = 0; i < TB_CHANNELS; i++)
					if (en_tab[i] && !pwm_bits[i])
						tick_one(i);
			end
			OP_SWITCH, OP_PWM, OP_TIMING, OP_PORT: begin
				if (ch >= TB_CHANNELS) begin
					st = ST_BAD_CHAN;
				end else if (c.opcode == OP_TIMING) begin
					mark_tab[ch]  = c.mark_ms;
					space_tab[ch] = c.space_ms;
				end else if (c.opcode == OP_PORT) begin
					en_tab[ch]  = c.enable_flag;
					inv_tab[ch] = c.invert_flag;
					pin_bits[ch] = c.enable_flag & (c.invert_flag ^ cur_bits[ch]);
				end else if (!en_tab[ch]) begin
					st = ST_NOT_CFG;
				end else if (c.opcode == OP_SWITCH) begin
					if (c.repeat_count != 0) begin
						if (pulses[ch] == 0) begin
							pulses[ch]    = c.repeat_count;
							want_bits[ch] = 1'b1;
						end
					end else begin
						pulses[ch]    = '0;
						want_bits[ch] = 1'b0;
					end
				end else if (c.pwm_on) begin
					pwm_bits[ch] = 1'b1;
				end else begin
					// release: pin stays until the next tick drives it off
					pulses[ch]    = '0;
					cur_bits[ch]  = 1'b1;
					want_bits[ch] = 1'b0;
					pwm_bits[ch]  = 1'b0;
				end
			end
			default: ;
		endcase
		e.drive_levels  = pin_bits;
		e.override_mask = pwm_bits;
		e.status        = st;
		expected_q.push_back(e);
	endfunction

	function void check_rsp(rsp_t r);
		rsp_t e;
		n_rsp++;
		if (expected_q.size() == 0) begin
			n_err++;
			if (n_err <= 10)
				$display("unexpected transaction: levels %h mask %h status %0d",
					r.drive_levels, r.override_mask, r.status);
			return;
		end
		e = expected_q.pop_front();
		if (r.drive_levels !== e.drive_levels || r.override_mask !== e.override_mask ||
				r.status !== e.status) begin
			n_err++;
			if (n_err <= 10) begin
				$display("mismatch on response %0d", n_rsp);
				$display("  levels exp %h got %h", e.drive_levels, r.drive_levels);
				$display("  mask   exp %h got %h", e.override_mask, r.override_mask);
				$display("  status exp %0d got %0d", e.status, r.status);
			end
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_multi_channel_pulse_generator_unit;

	localparam int              LIMIT      = 1000000;
	localparam int              RAND_ITEMS = 1230;
	localparam int              DRAIN      = 60;
	localparam int              HOLD_AT    = 400;
	localparam int              HOLD_LEN   = 600;
	localparam logic [2:0]      OP_SPARE   = 3'd5;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic hold_rsp  = 1'b0;

	pulse_checker sb;
	int n_sent     = 0;
	int burst_left = 0;
	int cycle_cnt  = 0;

	multi_channel_pulse_generator_unit #(
		.CHANNELS(TB_CHANNELS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				sb.apply_cmd(cmd);
			if (rsp_valid && rsp_ready)
				sb.check_rsp(rsp);
		end
	end

	function automatic cmd_t mk_cmd(logic [2:0] op, logic [5:0] ch, logic [31:0] count,
			logic pwm, logic [31:0] mark, logic [31:0] space, logic en, logic inv);
		cmd_t c;
		c.opcode       = op;
		c.channel      = ch;
		c.repeat_count = count;
		c.pwm_on       = pwm;
		c.mark_ms      = mark;
		c.space_ms     = space;
		c.enable_flag  = en;
		c.invert_flag  = inv;
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c);
		int gap;
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 15);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	// receiver: alternating stall patterns plus one long hold-off
	initial begin : rsp_side
		int rcv_cyc;
		int stall_left;
		rcv_cyc    = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			rcv_cyc++;
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
			end else begin
				case ((rcv_cyc / 256) % 4)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= rcv_cyc[0];
					2: rsp_ready <= ($urandom_range(0, 3) != 0);
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							rsp_ready <= 1'b0;
						end else begin
							if ($urandom_range(0, 7) == 0)
								stall_left = $urandom_range(1, 20);
							rsp_ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	initial begin : hold_off
		wait (n_sent >= HOLD_AT);
		hold_rsp <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin : watchdog
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		cmd_t c;
		int   pick;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_cmd(mk_cmd(OP_TICK, 6'd63, '1, 1'b1, '1, '1, 1'b1, 1'b1));
		send_cmd(mk_cmd(OP_SWITCH, 6'd0, 32'd3, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_PWM, 6'd0, '0, 1'b1, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_SWITCH, 6'd36, '1, 1'b0, '0, '0, 1'b1, 1'b0));
		send_cmd(mk_cmd(OP_TIMING, 6'd63, '0, 1'b0, '1, '1, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_PORT, 6'd40, '0, 1'b0, '0, '0, 1'b1, 1'b1));
		for (int k = 0; k < 3; k++)
			send_cmd(mk_cmd(OP_SPARE + 3'(k), 6'(k), '1, 1'b1, '1, '1, 1'b1, 1'b1));
		send_cmd(mk_cmd(OP_TIMING, 6'd0, '0, 1'b0, 32'd2, 32'd1, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_PORT, 6'd0, '0, 1'b0, '0, '0, 1'b1, 1'b0));
		send_cmd(mk_cmd(OP_PORT, 6'd35, '0, 1'b0, '0, '0, 1'b1, 1'b1));
		send_cmd(mk_cmd(OP_TIMING, 6'd35, '0, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_SWITCH, 6'd0, 32'd2, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_SWITCH, 6'd0, 32'd5, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_SWITCH, 6'd35, FOREVER, 1'b0, '0, '0, 1'b0, 1'b0));
		for (int k = 0; k < 4; k++)
			send_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_PWM, 6'd35, '0, 1'b1, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_PWM, 6'd35, '0, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_SWITCH, 6'd0, '0, 1'b0, '0, '0, 1'b0, 1'b0));
		send_cmd(mk_cmd(OP_PORT, 6'd0, '0, 1'b0, '0, '0, 1'b0, 1'b1));

		// random, biased toward a few busy channels so pulse trains run
		for (int k = 0; k < RAND_ITEMS; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				c.opcode = OP_TICK;
			else if (pick < 66)
				c.opcode = OP_SWITCH;
			else if (pick < 77)
				c.opcode = OP_TIMING;
			else if (pick < 88)
				c.opcode = OP_PORT;
			else if (pick < 96)
				c.opcode = OP_PWM;
			else
				c.opcode = OP_SPARE + 3'($urandom_range(0, 2));
			pick = $urandom_range(0, 9);
			if (pick < 6)
				c.channel = 6'($urandom_range(0, 7));
			else if (pick < 9)
				c.channel = 6'($urandom_range(0, TB_CHANNELS - 1));
			else
				c.channel = 6'($urandom_range(TB_CHANNELS, 63));
			pick = $urandom_range(0, 9);
			if (pick < 2)
				c.repeat_count = '0;
			else if (pick < 6)
				c.repeat_count = $urandom_range(1, 4);
			else if (pick < 8)
				c.repeat_count = FOREVER;
			else
				c.repeat_count = $urandom;
			c.mark_ms     = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom;
			c.space_ms    = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom;
			c.pwm_on      = 1'($urandom_range(0, 1));
			c.enable_flag = ($urandom_range(0, 4) != 0);
			c.invert_flag = 1'($urandom_range(0, 1));
			send_cmd(c);
		end
		cmd_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d commands (%0d ticks, %0d predicted pin edges)",
			sb.n_cmd, sb.n_ticks, sb.n_edges);
		$display("checked %0d responses, %0d mismatches", sb.n_rsp, sb.n_err);
		if (sb.n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mcpg_pkg.sv
rtl/mcpg_ram.sv
rtl/mcpg_queue.sv
rtl/mcpg_front.sv
rtl/mcpg_back.sv
rtl/multi_channel_pulse_generator_unit.sv
rtl/mcpg_checker.sv
sim/tb_multi_channel_pulse_generator_unit.sv
